// File: hdl/slbs_pkg.sv
// Shared types, codes and note tables for the status lamp and beep sequencer.
`timescale 1ns / 1ps

package slbs_pkg;

  // Field widths
  localparam int unsigned PeriodW  = 12;
  localparam int unsigned ToneW    = 12;
  localparam int unsigned NoteLenW = 9;

  // Request type codes
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_MODE    = 2'd1;
  localparam logic [1:0] REQ_CHIRP   = 2'd2;
  localparam logic [1:0] REQ_SILENCE = 2'd3;

  // Lamp mode codes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_GRANTED = 3'd1;
  localparam logic [2:0] MODE_DENIED  = 3'd2;
  localparam logic [2:0] MODE_WORKING = 3'd3;
  localparam logic [2:0] MODE_OFFLINE = 3'd4;
  localparam logic [2:0] MODE_FAULT   = 3'd5;

  // Chirp pattern codes
  localparam logic [1:0] CHIRP_READ   = 2'd0;
  localparam logic [1:0] CHIRP_ACCEPT = 2'd1;
  localparam logic [1:0] CHIRP_REJECT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WORKING = 2'd0;
  localparam logic [1:0] CFG_OFFLINE = 2'd1;
  localparam logic [1:0] CFG_FAULT   = 2'd2;

  // Period register reset values
  localparam logic [PeriodW-1:0] WORKING_PERIOD_RST = 12'd150;
  localparam logic [PeriodW-1:0] OFFLINE_PERIOD_RST = 12'd1200;
  localparam logic [PeriodW-1:0] FAULT_PERIOD_RST   = 12'd200;

  // Input request payload
  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] mode;
    logic [1:0] chirp;
  } in_t;

  // Result payload
  typedef struct packed {
    logic             green_on;
    logic             red_on;
    logic [ToneW-1:0] tone_hz;
  } out_t;

  // Configuration write port
  typedef struct packed {
    logic               we;
    logic [1:0]         idx;
    logic [PeriodW-1:0] data;
  } cfg_wr_t;

  // Next lamp levels handed from the lamp unit to the result register
  typedef struct packed {
    logic green;
    logic red;
  } lamp_lvl_t;

  // Note frequency in Hz for a pattern and note position; zero is a rest.
  function automatic logic [ToneW-1:0] note_hz(input logic [1:0] pat, input logic [1:0] idx);
    logic [ToneW-1:0] hz;
    case ({pat, idx})
      {CHIRP_READ,   2'd0}: hz = 12'd2200;
      {CHIRP_ACCEPT, 2'd0}: hz = 12'd1800;
      {CHIRP_ACCEPT, 2'd1}: hz = 12'd2600;
      {CHIRP_REJECT, 2'd0}: hz = 12'd420;
      {CHIRP_REJECT, 2'd2}: hz = 12'd420;
      default:              hz = '0;
    endcase
    return hz;
  endfunction

  // Note duration in ticks; positions beyond the pattern read as zero.
  function automatic logic [NoteLenW-1:0] note_len(input logic [1:0] pat,
                                                   input logic [1:0] idx);
    logic [NoteLenW-1:0] len;
    case ({pat, idx})
      {CHIRP_READ,   2'd0}: len = 9'd40;
      {CHIRP_ACCEPT, 2'd0}: len = 9'd90;
      {CHIRP_ACCEPT, 2'd1}: len = 9'd140;
      {CHIRP_REJECT, 2'd0}: len = 9'd180;
      {CHIRP_REJECT, 2'd1}: len = 9'd80;
      {CHIRP_REJECT, 2'd2}: len = 9'd320;
      default:              len = '0;
    endcase
    return len;
  endfunction

  // Number of notes in a pattern.
  function automatic logic [1:0] note_count(input logic [1:0] pat);
    logic [1:0] cnt;
    case (pat)
      CHIRP_READ:   cnt = 2'd1;
      CHIRP_ACCEPT: cnt = 2'd2;
      CHIRP_REJECT: cnt = 2'd3;
      default:      cnt = 2'd0;
    endcase
    return cnt;
  endfunction

endpackage

// File: hdl/slbs_lamp.sv
// Lamp unit: mode register, blink timer, period registers and lamp levels.
`timescale 1ns / 1ps

module slbs_lamp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  slbs_pkg::in_t       req_i,
  input  slbs_pkg::cfg_wr_t   cfg_i,
  output slbs_pkg::lamp_lvl_t lvl_o
);

  logic [2:0]                   mode_q, mode_d;
  logic                         phase_q, phase_d;
  logic [slbs_pkg::PeriodW-1:0] elapsed_q, elapsed_d;
  logic                         green_q, green_d;
  logic                         red_q, red_d;
  logic [slbs_pkg::PeriodW-1:0] working_q, offline_q, fault_q;
  logic [slbs_pkg::PeriodW-1:0] period;
  logic [slbs_pkg::PeriodW-1:0] elapsed_inc;
  logic                         due;

  // Period of the current blinking mode and the saturating timer step.
  always_comb begin
    unique case (mode_q)
      slbs_pkg::MODE_OFFLINE: period = offline_q;
      slbs_pkg::MODE_FAULT:   period = fault_q;
      default:                period = working_q;
    endcase
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    due         = (elapsed_inc >= period);
  end

  // Next state for one accepted request.
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    green_d   = green_q;
    red_d     = red_q;
    if (fire_i) begin
      unique case (req_i.req_type) inside
        slbs_pkg::REQ_TICK: begin
          unique case (mode_q) inside
            slbs_pkg::MODE_IDLE: begin
              green_d = 1'b0;
              red_d   = 1'b0;
            end
            slbs_pkg::MODE_GRANTED: begin
              green_d = 1'b1;
              red_d   = 1'b0;
            end
            slbs_pkg::MODE_DENIED: begin
              green_d = 1'b0;
              red_d   = 1'b1;
            end
            slbs_pkg::MODE_WORKING, slbs_pkg::MODE_OFFLINE, slbs_pkg::MODE_FAULT: begin
              if (due) begin
                phase_d   = ~phase_q;
                elapsed_d = '0;
                if (mode_q == slbs_pkg::MODE_WORKING) begin
                  green_d = ~phase_q;
                  red_d   = phase_q;
                end else begin
                  green_d = 1'b0;
                  red_d   = ~phase_q;
                end
              end else begin
                elapsed_d = elapsed_inc;
              end
            end
            default: begin
              // Undefined modes leave the lamps and the timer alone.
            end
          endcase
        end
        slbs_pkg::REQ_MODE: begin
          if (req_i.mode != mode_q) begin
            mode_d    = req_i.mode;
            phase_d   = 1'b0;
            elapsed_d = '0;
          end
        end
        slbs_pkg::REQ_CHIRP, slbs_pkg::REQ_SILENCE: begin
          // Tone requests do not touch the lamps.
        end
        default: begin
        end
      endcase
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= slbs_pkg::MODE_IDLE;
      phase_q   <= 1'b0;
      elapsed_q <= '0;
      green_q   <= 1'b0;
      red_q     <= 1'b0;
      working_q <= slbs_pkg::WORKING_PERIOD_RST;
      offline_q <= slbs_pkg::OFFLINE_PERIOD_RST;
      fault_q   <= slbs_pkg::FAULT_PERIOD_RST;
    end else begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      green_q   <= green_d;
      red_q     <= red_d;
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          slbs_pkg::CFG_WORKING: working_q <= cfg_i.data;
          slbs_pkg::CFG_OFFLINE: offline_q <= cfg_i.data;
          slbs_pkg::CFG_FAULT:   fault_q   <= cfg_i.data;
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end
    end
  end

  assign lvl_o.green = green_d;
  assign lvl_o.red   = red_d;

  // A real mode change restarts the blink timer from phase zero.
  a_mode_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == slbs_pkg::REQ_MODE && req_i.mode != mode_q
    |=> elapsed_q == '0 && !phase_q)
    else $error("mode change did not clear the blink timer");

  // A tick in idle mode turns both lamps off.
  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == slbs_pkg::REQ_TICK && mode_q == slbs_pkg::MODE_IDLE
    |=> !green_q && !red_q)
    else $error("idle tick left a lamp lit");

endmodule

// File: hdl/slbs_tone.sv
// Tone unit: chirp note sequencer driving the buzzer frequency.
`timescale 1ns / 1ps

module slbs_tone (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  slbs_pkg::in_t              req_i,
  output logic [slbs_pkg::ToneW-1:0] tone_o
);

  logic                          running_q, running_d;
  logic [1:0]                    pat_q, pat_d;
  logic [1:0]                    idx_q, idx_d;
  logic [slbs_pkg::NoteLenW-1:0] elapsed_q, elapsed_d;
  logic [slbs_pkg::ToneW-1:0]    level_q, level_d;
  logic [slbs_pkg::NoteLenW-1:0] elapsed_inc;
  logic [1:0]                    idx_next;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign idx_next    = idx_q + 2'd1;

  // Next state for one accepted request.
  always_comb begin
    running_d = running_q;
    pat_d     = pat_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    level_d   = level_q;
    if (fire_i) begin
      unique case (req_i.req_type)
        slbs_pkg::REQ_TICK: begin
          if (running_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= slbs_pkg::note_len(pat_q, idx_q)) begin
              idx_d = idx_next;
              if (idx_next >= slbs_pkg::note_count(pat_q)) begin
                level_d   = '0;
                running_d = 1'b0;
              end else begin
                level_d   = slbs_pkg::note_hz(pat_q, idx_next);
                elapsed_d = '0;
              end
            end
          end
        end
        slbs_pkg::REQ_CHIRP: begin
          if (req_i.chirp <= slbs_pkg::CHIRP_REJECT) begin
            pat_d     = req_i.chirp;
            idx_d     = 2'd0;
            elapsed_d = '0;
            running_d = 1'b1;
            level_d   = slbs_pkg::note_hz(req_i.chirp, 2'd0);
          end
        end
        slbs_pkg::REQ_SILENCE: begin
          running_d = 1'b0;
          level_d   = '0;
        end
        slbs_pkg::REQ_MODE: begin
          // Mode requests do not touch the tone.
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pat_q     <= slbs_pkg::CHIRP_READ;
      idx_q     <= 2'd0;
      elapsed_q <= '0;
      level_q   <= '0;
    end else begin
      running_q <= running_d;
      pat_q     <= pat_d;
      idx_q     <= idx_d;
      elapsed_q <= elapsed_d;
      level_q   <= level_d;
    end
  end

  assign tone_o = level_d;

  // The buzzer is only driven while a sequence is running.
  a_silent_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> level_q == '0)
    else $error("tone level set while no sequence runs");

  // A silence request stops the sequence.
  a_silence_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == slbs_pkg::REQ_SILENCE |=> !running_q)
    else $error("silence request left the sequence running");

endmodule

// File: hdl/status_lamp_and_beep_sequencer.sv
// Top level of the status lamp and beep sequencer: handshake and result register.
`timescale 1ns / 1ps

// Every accepted request (a one-millisecond tick, a mode change, a chirp start
// or a silence) yields exactly one result holding the green and red lamp levels
// and the buzzer frequency after that request. A request is taken whenever the
// result register is free or being emptied: the lamp and tone units update their
// state in the cycle of acceptance and the result appears from the result
// register in the cycle after. The result register takes a new request while the
// previous result is being taken, so the block sustains one request per cycle and
// stalls only while a result is held back. The user must write period registers through
// the configuration port only while no request is in flight; the block does not enforce it.

module status_lamp_and_beep_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  slbs_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output slbs_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [slbs_pkg::PeriodW-1:0] cfg_data_i
);

  logic                       in_fire;
  logic                       out_valid_q;
  slbs_pkg::out_t             out_q;
  slbs_pkg::cfg_wr_t          cfg;
  slbs_pkg::lamp_lvl_t        lvl;
  logic [slbs_pkg::ToneW-1:0] tone;

  // A request is taken whenever the result register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  slbs_lamp u_lamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .req_i  (in_data_i),
    .cfg_i  (cfg),
    .lvl_o  (lvl)
  );

  slbs_tone u_tone (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .req_i  (in_data_i),
    .tone_o (tone)
  );

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.green_on <= lvl.green;
      out_q.red_on   <= lvl.red;
      out_q.tone_hz  <= tone;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every accepted request leaves a result behind it.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // A silence request always reports a silent buzzer.
  a_silence_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.req_type == slbs_pkg::REQ_SILENCE |=> out_q.tone_hz == '0)
    else $error("silence request reported a tone");

endmodule
